>>> hw/rtl/lbbc_pkg.sv
// Shared types and constants for the LRU byte-budget cache policy.
package lbbc_pkg;

  localparam logic [2:0] OP_ADD       = 3'd0;
  localparam logic [2:0] OP_ACCESS    = 3'd1;
  localparam logic [2:0] OP_ADD_MEM   = 3'd2;
  localparam logic [2:0] OP_TRIM      = 3'd3;
  localparam logic [2:0] OP_EVICT_ALL = 3'd4;

  localparam logic [39:0] LIMIT_RESET = 40'd1073741824;
  localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;
  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_LOG,
    ST_EXEC,
    ST_EVICT,
    ST_OUT
  } lbbc_state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic log_step;
    logic exec_step;
    logic evict_step;
    logic zero_total;
    logic out_load;
  } lbbc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic need_evict;
    logic is_evict_all;
    logic list_empty;
    logic out_busy;
  } lbbc_stat_t;

endpackage

>>> hw/rtl/lbbc_ctrl.sv
// Controller state machine for the LRU byte-budget cache policy.
module lbbc_ctrl import lbbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  lbbc_stat_t stat,
  output lbbc_cmd_t  cmd,
  output logic       in_ready
);
  lbbc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = !stat.out_busy;
        if (in_fire) begin
          cmd.capture = 1'b1;
          state_next = ST_LOG;
        end
      end
      ST_LOG: begin
        cmd.log_step = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec_step = 1'b1;
        state_next = ST_EVICT;
      end
      ST_EVICT: begin
        if (stat.need_evict) begin
          cmd.evict_step = 1'b1;
        end else begin
          cmd.zero_total = stat.is_evict_all;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        cmd.out_load = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

>>> hw/rtl/lbbc_datapath.sv
// List, byte and history datapath for the LRU byte-budget cache policy.
module lbbc_datapath import lbbc_pkg::*; #(
  parameter int SLOTS   = 32,
  parameter int HISTORY = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  lbbc_cmd_t   cmd,
  output lbbc_stat_t  stat,
  input  logic [2:0]  in_op,
  input  logic [4:0]  in_slot,
  input  logic [31:0] in_bytes,
  input  logic [39:0] byte_limit,
  input  logic        out_stall,
  output logic        out_valid,
  output logic        evicted_valid,
  output logic [4:0]  evicted_slot,
  output logic        last,
  output logic [10:0] recent_hits,
  output logic [10:0] recent_misses,
  output logic [39:0] memory_total
);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HW = $clog2(HISTORY);
  localparam int FW = $clog2(HISTORY + 1);
  localparam int QD = 32;

  logic [SW-1:0] older_link [SLOTS];
  logic [SW-1:0] newer_link [SLOTS];
  logic [SLOTS-1:0] listed;
  logic [SW-1:0] front_slot, back_slot;
  logic [31:0] slot_bytes [SLOTS];
  logic [39:0] byte_total;

  logic hist_mem [HISTORY];
  logic [HW-1:0] history_pos;
  logic [FW-1:0] history_fill, hit_tally;
  logic [HW:0] clr_idx;
  logic hist_old;

  logic [2:0] op;
  logic [SW-1:0] s;
  logic [31:0] bytes_r;
  logic in_range;
  logic kick_en;

  // eviction report queue
  logic [4:0] evq [QD];
  logic [5:0] ev_cnt, rd_idx;
  logic busy;

  assign stat.clear_done = (clr_idx == (HW+1)'(HISTORY - 1));
  assign stat.list_empty = !listed[front_slot];
  assign stat.is_evict_all = in_range && op == OP_EVICT_ALL;
  assign stat.need_evict = in_range && !stat.list_empty &&
      ((op == OP_EVICT_ALL) || (kick_en && byte_total > byte_limit));
  assign stat.out_busy = busy;

  // history ring: single write port, registered read of the outgoing entry
  always_ff @(posedge clk) begin
    if (cmd.clear_step) hist_mem[clr_idx[HW-1:0]] <= 1'b0;
    else if (cmd.log_step && (op == OP_ADD || op == OP_ACCESS) && in_range)
      hist_mem[history_pos] <= (op == OP_ACCESS);
    if (cmd.capture) hist_old <= hist_mem[history_pos];
  end

  logic [31:0] room, delta;
  logic [40:0] tsum;
  always_comb begin
    room  = MAX32 - slot_bytes[s];
    delta = (bytes_r < room) ? bytes_r : room;
    tsum  = {1'b0, byte_total} + {9'd0, delta};
  end

  // unlink u (s, or back for evictions); the push to the front is done in the exec step
  task automatic do_unlink(input logic [SW-1:0] u);
    if (u == front_slot && u == back_slot) begin
    end else if (u == front_slot) begin
      front_slot <= older_link[u];
    end else if (u == back_slot) begin
      back_slot <= newer_link[u];
    end else begin
      older_link[newer_link[u]] <= older_link[u];
      newer_link[older_link[u]] <= newer_link[u];
    end
  endtask

  logic [SW-1:0] eb;
  logic [31:0] ebytes;
  assign eb = back_slot;
  assign ebytes = slot_bytes[eb];

  // Add/access unlink in the log step and push to the front in the exec step,
  // so only one set of link writes lands per cycle.
  logic push_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      listed <= '0;
      front_slot <= '0;
      back_slot <= '0;
      byte_total <= '0;
      history_pos <= '0;
      history_fill <= '0;
      hit_tally <= '0;
      clr_idx <= '0;
      ev_cnt <= '0;
      rd_idx <= '0;
      busy <= 1'b0;
      out_valid <= 1'b0;
      push_pend <= 1'b0;
      for (int i = 0; i < SLOTS; i++) slot_bytes[i] <= '0;
    end else begin
      if (cmd.clear_step) clr_idx <= clr_idx + 1'b1;
      if (cmd.capture) begin
        op <= in_op;
        s <= SW'(in_slot);
        bytes_r <= in_bytes;
        in_range <= (32'(in_slot) < SLOTS) || in_op == OP_TRIM || in_op == OP_EVICT_ALL;
        ev_cnt <= '0;
      end
      // trim always checks the budget; growth only when the slot is listed
      if (cmd.log_step)
        kick_en <= in_range && (op == OP_TRIM || (op == OP_ADD_MEM && listed[s]));
      if (cmd.log_step && in_range) begin
        if (op == OP_ADD || op == OP_ACCESS) begin
          if (history_fill == FW'(HISTORY))
            hit_tally <= hit_tally - FW'(hist_old) + FW'(op == OP_ACCESS);
          else begin
            history_fill <= history_fill + 1'b1;
            hit_tally <= hit_tally + FW'(op == OP_ACCESS);
          end
          history_pos <= (32'(history_pos) + 1 >= HISTORY) ? '0 : history_pos + 1'b1;
        end
        if ((op == OP_ADD && listed[s]) ||
            (op == OP_ACCESS && listed[s] && s != front_slot)) begin
          do_unlink(s);
          listed[s] <= 1'b0;
        end
        push_pend <= (op == OP_ADD) || (op == OP_ACCESS && listed[s] && s != front_slot);
        if (op == OP_ADD_MEM) begin
          slot_bytes[s] <= slot_bytes[s] + delta;
          if (listed[s]) byte_total <= tsum[40] ? MAX40 : tsum[39:0];
        end
      end
      if (cmd.exec_step && push_pend) begin
        push_pend <= 1'b0;
        if (!listed[front_slot]) back_slot <= s;
        else begin
          older_link[s] <= front_slot;
          newer_link[front_slot] <= s;
        end
        front_slot <= s;
        listed[s] <= 1'b1;
      end
      if (cmd.evict_step) begin
        do_unlink(eb);
        listed[eb] <= 1'b0;
        byte_total <= (byte_total > 40'(ebytes)) ? byte_total - 40'(ebytes) : '0;
        slot_bytes[eb] <= '0;
        if (ev_cnt < 6'd32) begin
          evq[ev_cnt[4:0]] <= 5'(eb);
          ev_cnt <= ev_cnt + 1'b1;
        end
      end
      if (cmd.zero_total) byte_total <= '0;
      if (cmd.out_load) begin
        busy <= 1'b1;
        out_valid <= 1'b1;
        rd_idx <= '0;
      end else if (out_valid && !out_stall) begin
        if (rd_idx + 1'b1 >= ev_cnt) begin
          out_valid <= 1'b0;
          busy <= 1'b0;
        end else rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  assign evicted_valid = (ev_cnt != 0);
  assign evicted_slot  = (ev_cnt != 0) ? evq[rd_idx[4:0]] : 5'd0;
  assign last          = (ev_cnt == 0) || (rd_idx + 1'b1 == ev_cnt);
  assign recent_hits   = 11'(hit_tally);
  assign recent_misses = 11'(history_fill - hit_tally);
  assign memory_total  = byte_total;
endmodule

>>> hw/rtl/lru_byte_budget_cache_policy.sv
// Top level of the LRU byte-budget cache policy.
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_stall  | op, slot, bytes
//  out     | out | out_valid/out_stall| evicted_valid..memory_total
//  cfg     | in  | APB psel/penable   | byte_limit at address 0
// After its input transfer an item passes through history/unlink, push, budget check and
// result load, the budget check repeating for each evicted slot as the eviction walk takes
// the list tail once a cycle; its first result shows in the cycle after the result load.
// Results go out one per transfer; the next input is taken at the earliest in the cycle
// after the last result transfer.
// After reset a clearing pass zeroes the history ring, with in_stall high.
module lru_byte_budget_cache_policy import lbbc_pkg::*; #(
  parameter int SLOTS   = 32,
  parameter int HISTORY = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [4:0]  slot,
  input  logic [31:0] bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        evicted_valid,
  output logic [4:0]  evicted_slot,
  output logic        last,
  output logic [10:0] recent_hits,
  output logic [10:0] recent_misses,
  output logic [39:0] memory_total,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  lbbc_cmd_t  cmd;
  lbbc_stat_t stat;
  logic in_ready;
  logic [39:0] byte_limit;

  assign in_stall = !in_ready;
  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {24'd0, byte_limit} : 64'd0;

  // hold the limit; a write lands only at the access phase
  always_ff @(posedge clk) begin
    if (rst) byte_limit <= LIMIT_RESET;
    else if (psel && penable && pwrite && paddr == 3'd0) byte_limit <= pwdata[39:0];
  end

  lbbc_ctrl u_ctrl (
    .clk, .rst, .in_fire(in_valid && in_ready), .stat, .cmd, .in_ready
  );

  lbbc_datapath #(.SLOTS(SLOTS), .HISTORY(HISTORY)) u_dp (
    .clk, .rst, .cmd, .stat,
    .in_op(op), .in_slot(slot), .in_bytes(bytes), .byte_limit,
    .out_stall, .out_valid, .evicted_valid, .evicted_slot, .last,
    .recent_hits, .recent_misses, .memory_total
  );
endmodule

>>> hw/rtl/lbbc_checker.sv
// Port-level checker for the LRU byte-budget cache policy, bound to the top level.
module lbbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        last,
  input logic        evicted_valid,
  input logic [4:0]  evicted_slot,
  input logic [10:0] recent_hits,
  input logic [10:0] recent_misses
);
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while results pending");
  a_status_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !evicted_valid) |-> (evicted_slot == 5'd0 && last))
    else $error("status result malformed");
  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, recent_hits} + {1'b0, recent_misses} <= 12'd1024))
    else $error("history counts exceed ring");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(evicted_slot)))
    else $error("stalled result changed");
endmodule

bind lru_byte_budget_cache_policy lbbc_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .last,
  .evicted_valid, .evicted_slot, .recent_hits, .recent_misses
);
